// ===== design/spg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spg_pkg;

	localparam int MAX_ANGLE_DEF = 180;

	localparam int PULSE_W  = 12;
	localparam int PERIOD_W = 16;
	localparam int BURST_W  = 8;
	localparam int ANGLE_W  = 8;
	localparam int VALUE_W  = 16;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 3;

	// widest product of pulse span and angle is below 2**PROD_W
	localparam int PROD_W = PULSE_W + ANGLE_W;

	localparam logic [PULSE_W-1:0]  MIN_PULSE_RST    = 12'd500;
	localparam logic [PULSE_W-1:0]  MAX_PULSE_RST    = 12'd2500;
	localparam logic [PULSE_W-1:0]  CENTER_PULSE_RST = 12'd1500;
	localparam logic [PERIOD_W-1:0] PERIOD_LEN_RST   = 16'd20000;
	localparam logic [BURST_W-1:0]  BURST_LEN_RST    = 8'd10;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_PULSE    = 3'd0,
		REG_MAX_PULSE    = 3'd1,
		REG_CENTER_PULSE = 3'd2,
		REG_PERIOD_LEN   = 3'd3,
		REG_BURST_LEN    = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		ACT_TICK  = 3'd0,
		ACT_INIT  = 3'd1,
		ACT_SET   = 3'd2,
		ACT_REL   = 3'd3,
		ACT_SPEED = 3'd4
	} action_t;

	typedef struct packed {
		logic [PULSE_W-1:0]  min_pulse;
		logic [PULSE_W-1:0]  max_pulse;
		logic [PULSE_W-1:0]  center_pulse;
		logic [PERIOD_W-1:0] period_len;
		logic [BURST_W-1:0]  burst_len;
		logic                span_neg;
	} cfg_t;

	typedef struct packed {
		logic               pin_level;
		logic [ANGLE_W-1:0] angle_now;
		logic               busy_res;
		logic [PULSE_W-1:0] pulse_now;
		logic               ready_res;
	} res_t;

endpackage

`default_nettype wire

// ===== design/spg_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spg_cfg_regs
	import spg_pkg::*;
#(
	parameter int MAX_ANGLE = MAX_ANGLE_DEF,
	parameter int SCALE_W   = PULSE_W + PROD_W + $clog2(MAX_ANGLE) + 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	output cfg_t                      cfg,
	output logic [SCALE_W-1:0]        scale
);

	localparam int  SHIFT   = PROD_W + $clog2(MAX_ANGLE);
	localparam int  RECIP_W = SHIFT + 1;
	localparam longint RECIP_VAL = ((64'd1 << SHIFT) + MAX_ANGLE - 1) / MAX_ANGLE;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

	logic [PULSE_W-1:0]  min_pulse_q;
	logic [PULSE_W-1:0]  max_pulse_q;
	logic [PULSE_W-1:0]  center_pulse_q;
	logic [PERIOD_W-1:0] period_len_q;
	logic [BURST_W-1:0]  burst_len_q;
	logic [SCALE_W-1:0]  scale_q;
	logic                span_neg_q;
	logic                span_neg;
	logic [PULSE_W-1:0]  span_mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pulse_q    <= MIN_PULSE_RST;
			max_pulse_q    <= MAX_PULSE_RST;
			center_pulse_q <= CENTER_PULSE_RST;
			period_len_q   <= PERIOD_LEN_RST;
			burst_len_q    <= BURST_LEN_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MIN_PULSE:    min_pulse_q    <= cfg_data[PULSE_W-1:0];
				REG_MAX_PULSE:    max_pulse_q    <= cfg_data[PULSE_W-1:0];
				REG_CENTER_PULSE: center_pulse_q <= cfg_data[PULSE_W-1:0];
				REG_PERIOD_LEN:   period_len_q   <= cfg_data[PERIOD_W-1:0];
				REG_BURST_LEN:    burst_len_q    <= cfg_data[BURST_W-1:0];
				default: ;
			endcase
		end
	end

	// |max - min| times reciprocal of MAX_ANGLE, registered from the stored settings
	assign span_neg = min_pulse_q > max_pulse_q;
	assign span_mag = span_neg ? (min_pulse_q - max_pulse_q) : (max_pulse_q - min_pulse_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q    <= SCALE_W'(PULSE_W'(MAX_PULSE_RST - MIN_PULSE_RST)) * SCALE_W'(RECIP);
			span_neg_q <= 1'b0;
		end else begin
			scale_q    <= SCALE_W'(span_mag) * SCALE_W'(RECIP);
			span_neg_q <= span_neg;
		end
	end

	always_comb begin
		cfg.min_pulse    = min_pulse_q;
		cfg.max_pulse    = max_pulse_q;
		cfg.center_pulse = center_pulse_q;
		cfg.period_len   = period_len_q;
		cfg.burst_len    = burst_len_q;
		cfg.span_neg     = span_neg_q;
	end

	assign scale = scale_q;

endmodule

`default_nettype wire

// ===== design/spg_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spg_core
	import spg_pkg::*;
#(
	parameter int MAX_ANGLE = MAX_ANGLE_DEF,
	parameter int SCALE_W   = PULSE_W + PROD_W + $clog2(MAX_ANGLE) + 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               go,
	input  wire logic [2:0]         action,
	input  wire logic [VALUE_W-1:0] value,
	input  cfg_t                    cfg,
	input  wire logic [SCALE_W-1:0] scale,
	output res_t                    res
);

	localparam int SHIFT = PROD_W + $clog2(MAX_ANGLE);
	localparam logic [ANGLE_W-1:0] MAX_ANG    = ANGLE_W'(MAX_ANGLE);
	localparam logic [ANGLE_W-1:0] CENTER_ANG = ANGLE_W'(MAX_ANGLE / 2);

	logic                init_q;
	logic [ANGLE_W-1:0]  angle_q;
	logic [PULSE_W-1:0]  pulse_q;
	logic [PERIOD_W-1:0] phase_q;
	logic [BURST_W-1:0]  bursts_q;

	logic                init_d;
	logic [ANGLE_W-1:0]  angle_d;
	logic [PULSE_W-1:0]  pulse_d;
	logic [PERIOD_W-1:0] phase_d;
	logic [BURST_W-1:0]  bursts_d;
	logic                pin;

	logic                  do_angle;
	logic                  do_speed;
	logic [ANGLE_W-1:0]    ang_sel;
	logic [VALUE_W:0]      rel_sum;
	logic [VALUE_W:0]      rel_mag;
	logic [PERIOD_W-1:0]   per;
	logic [PERIOD_W:0]     phase_inc;
	logic [SCALE_W+ANGLE_W-1:0] ang_prod;
	logic [PULSE_W-1:0]    ang_quot;
	logic [PULSE_W-1:0]    ang_pulse;
	logic signed [21:0]    sv22;
	logic signed [21:0]    spd_raw;
	logic [PULSE_W-1:0]    spd_pulse;

	always_comb begin
		sv22    = 22'(signed'(value));
		spd_raw = $signed({10'd0, cfg.center_pulse}) + (sv22 <<< 3) + (sv22 <<< 1);
		if (value != '0 && !value[VALUE_W-1] && spd_raw > $signed({10'd0, cfg.max_pulse}))
			spd_pulse = cfg.max_pulse;
		else if (value[VALUE_W-1] && spd_raw < $signed({10'd0, cfg.min_pulse}))
			spd_pulse = cfg.min_pulse;
		else
			spd_pulse = spd_raw[PULSE_W-1:0];
	end

	always_comb begin
		do_angle = 1'b0;
		do_speed = 1'b0;
		ang_sel  = angle_q;
		init_d   = init_q;
		rel_sum  = {{(VALUE_W+1-ANGLE_W){1'b0}}, angle_q} + {1'b0, value};
		rel_mag  = (VALUE_W+1)'(-$signed({value[VALUE_W-1], value}));
		case (action_t'(action))
			ACT_INIT: begin
				init_d   = 1'b1;
				do_angle = 1'b1;
				ang_sel  = CENTER_ANG;
			end
			ACT_SET: begin
				do_angle = init_q;
				ang_sel  = (value > VALUE_W'(MAX_ANG)) ? MAX_ANG : value[ANGLE_W-1:0];
			end
			ACT_REL: begin
				do_angle = init_q && (value != '0);
				if (!value[VALUE_W-1])
					ang_sel = (rel_sum > (VALUE_W+1)'(MAX_ANG)) ? MAX_ANG
						: rel_sum[ANGLE_W-1:0];
				else
					ang_sel = (rel_mag >= (VALUE_W+1)'(angle_q)) ? '0
						: angle_q - rel_mag[ANGLE_W-1:0];
			end
			ACT_SPEED: begin
				do_speed = init_q;
			end
			default: ;
		endcase
	end

	// min + (max - min) * angle / MAX_ANGLE, truncated toward zero
	always_comb begin
		ang_prod  = scale * ang_sel;
		ang_quot  = ang_prod[SHIFT+PULSE_W-1:SHIFT];
		ang_pulse = cfg.span_neg ? (cfg.min_pulse - ang_quot) : (cfg.min_pulse + ang_quot);
	end

	always_comb begin
		per       = (cfg.period_len == '0) ? PERIOD_W'(1) : cfg.period_len;
		phase_inc = {1'b0, phase_q} + 1'b1;
		pin       = 1'b0;
		angle_d   = angle_q;
		pulse_d   = pulse_q;
		phase_d   = phase_q;
		bursts_d  = bursts_q;
		if (action_t'(action) == ACT_TICK) begin
			if (bursts_q != '0) begin
				pin = {4'd0, pulse_q} > phase_q;
				if (phase_inc >= {1'b0, per}) begin
					phase_d  = '0;
					bursts_d = bursts_q - 1'b1;
				end else begin
					phase_d = phase_inc[PERIOD_W-1:0];
				end
			end
		end else if (do_angle || do_speed) begin
			if (do_angle)
				angle_d = ang_sel;
			pulse_d  = do_angle ? ang_pulse : spd_pulse;
			phase_d  = '0;
			bursts_d = cfg.burst_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q   <= 1'b0;
			angle_q  <= CENTER_ANG;
			pulse_q  <= CENTER_PULSE_RST;
			phase_q  <= '0;
			bursts_q <= '0;
		end else if (go) begin
			init_q   <= init_d;
			angle_q  <= angle_d;
			pulse_q  <= pulse_d;
			phase_q  <= phase_d;
			bursts_q <= bursts_d;
		end
	end

	always_comb begin
		res.pin_level = pin;
		res.angle_now = angle_d;
		res.busy_res  = bursts_d != '0;
		res.pulse_now = pulse_d;
		res.ready_res = init_d;
	end

endmodule

`default_nettype wire

// ===== design/servo_pulse_generator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Servo pulse generator. Takes one request per clock while the output is not held
// by stall: a one-microsecond tick or a command (init, set angle, relative rotate,
// speed). A request is held in an input register, then the state update and the
// result are computed from it and placed in an output register; a new request is
// taken in every cycle while the output is not held by stall. One state update per
// cycle sets that rate. A configuration write takes effect once the angle-to-pulse
// scale factor is recomputed into a register.
module servo_pulse_generator_unit
	import spg_pkg::*;
#(
	parameter int MAX_ANGLE = MAX_ANGLE_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [2:0]           action,
	input  wire logic [VALUE_W-1:0]   value,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      pin_level,
	output logic [ANGLE_W-1:0]        angle_now,
	output logic                      busy_res,
	output logic [PULSE_W-1:0]        pulse_now,
	output logic                      ready_res
);

	localparam int SCALE_W = PULSE_W + PROD_W + $clog2(MAX_ANGLE) + 1;

	cfg_t               cfg;
	logic [SCALE_W-1:0] scale;
	res_t               res;
	res_t               res_q;

	logic               valid_s1;
	logic [2:0]         action_s1;
	logic [VALUE_W-1:0] value_s1;
	logic               out_valid_q;
	logic               advance;
	logic               accept;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	spg_cfg_regs #(
		.MAX_ANGLE(MAX_ANGLE),
		.SCALE_W(SCALE_W)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg),
		.scale(scale)
	);

	spg_core #(
		.MAX_ANGLE(MAX_ANGLE),
		.SCALE_W(SCALE_W)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.go(advance),
		.action(action_s1),
		.value(value_s1),
		.cfg(cfg),
		.scale(scale),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action;
			value_s1  <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign pin_level = res_q.pin_level;
	assign angle_now = res_q.angle_now;
	assign busy_res  = res_q.busy_res;
	assign pulse_now = res_q.pulse_now;
	assign ready_res = res_q.ready_res;

endmodule

`default_nettype wire

// ===== sim/servo_pulse_checker.sv =====
`timescale 1ns / 1ps

module servo_pulse_checker
	import spg_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [2:0]           action,
	input  logic [VALUE_W-1:0]   value,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic                 pin_level,
	input  logic [ANGLE_W-1:0]   angle_now,
	input  logic                 busy_res,
	input  logic [PULSE_W-1:0]   pulse_now,
	input  logic                 ready_res,
	output int                   mismatches,
	output int                   waiting,
	output int                   checked
);
	localparam int MAX_ANG = MAX_ANGLE_DEF;

	logic [PULSE_W-1:0]  min_pulse;
	logic [PULSE_W-1:0]  max_pulse;
	logic [PULSE_W-1:0]  center_pulse;
	logic [PERIOD_W-1:0] period_len;
	logic [BURST_W-1:0]  burst_len;

	logic                ready;
	logic [ANGLE_W-1:0]  angle;
	logic [PULSE_W-1:0]  pulse;
	logic [PERIOD_W-1:0] phase;
	logic [BURST_W-1:0]  periods_left;

	res_t expected_servo[$];

	task automatic report_mismatch(input string field, input int got, input int want);
		mismatches++;
		$display("%0t: %s mismatch, got %0d expected %0d", $time, field, got, want);
	endtask

	function automatic logic [PULSE_W-1:0] pulse_for_angle(input int ang);
		int span;
		int p;
		span = int'(max_pulse) - int'(min_pulse);
		p = int'(min_pulse) + (span * ang) / MAX_ANG;
		return p[PULSE_W-1:0];
	endfunction

	task automatic start_burst(input logic [PULSE_W-1:0] width);
		pulse = width;
		phase = '0;
		periods_left = burst_len;
	endtask

	task automatic aim_at(input int ang);
		if (ang > MAX_ANG)
			ang = MAX_ANG;
		angle = ang[ANGLE_W-1:0];
		start_burst(pulse_for_angle(ang));
	endtask

	// one request in, state after it out
	task automatic servo_step(input logic [2:0] act, input logic [VALUE_W-1:0] raw,
			output res_t r);
		int sval;
		int target;
		logic [PERIOD_W-1:0] per;
		r.pin_level = 1'b0;
		sval = int'($signed(raw));
		if (act == ACT_TICK) begin
			if (periods_left != 0) begin
				per = (period_len == 0) ? 16'd1 : period_len;
				r.pin_level = (phase < pulse);
				phase = phase + 1'b1;
				if (phase >= per) begin
					phase = '0;
					periods_left = periods_left - 1'b1;
				end
			end
		end else if (act == ACT_INIT) begin
			ready = 1'b1;
			aim_at(MAX_ANG / 2);
		end else if (act <= ACT_SPEED && ready) begin
			case (act)
			ACT_SET: aim_at(int'(raw));
			ACT_REL: begin
				if (sval > 0)
					aim_at(int'(angle) + sval);
				else if (sval < 0)
					aim_at((-sval >= int'(angle)) ? 0 : int'(angle) + sval);
			end
			default: begin
				target = int'(center_pulse) + sval * 10;
				if (sval > 0 && target > int'(max_pulse))
					target = int'(max_pulse);
				if (sval < 0 && target < int'(min_pulse))
					target = int'(min_pulse);
				start_burst(target[PULSE_W-1:0]);
			end
			endcase
		end
		r.angle_now = angle;
		r.busy_res = (periods_left != 0);
		r.pulse_now = pulse;
		r.ready_res = ready;
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		res_t want;
		if (!arst_n) begin
			min_pulse = MIN_PULSE_RST;
			max_pulse = MAX_PULSE_RST;
			center_pulse = CENTER_PULSE_RST;
			period_len = PERIOD_LEN_RST;
			burst_len = BURST_LEN_RST;
			ready = 1'b0;
			angle = ANGLE_W'(MAX_ANG / 2);
			pulse = CENTER_PULSE_RST;
			phase = '0;
			periods_left = '0;
			expected_servo.delete();
			mismatches = 0;
			waiting = 0;
			checked = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				REG_MIN_PULSE:    min_pulse = cfg_data[PULSE_W-1:0];
				REG_MAX_PULSE:    max_pulse = cfg_data[PULSE_W-1:0];
				REG_CENTER_PULSE: center_pulse = cfg_data[PULSE_W-1:0];
				REG_PERIOD_LEN:   period_len = cfg_data[PERIOD_W-1:0];
				REG_BURST_LEN:    burst_len = cfg_data[BURST_W-1:0];
				default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_servo.size() == 0) begin
					report_mismatch("result with no request", 1, 0);
				end else begin
					want = expected_servo.pop_front();
					checked++;
					if (pin_level !== want.pin_level)
						report_mismatch("pin_level", pin_level, want.pin_level);
					if (angle_now !== want.angle_now)
						report_mismatch("angle_now", angle_now, want.angle_now);
					if (busy_res !== want.busy_res)
						report_mismatch("busy_res", busy_res, want.busy_res);
					if (pulse_now !== want.pulse_now)
						report_mismatch("pulse_now", pulse_now, want.pulse_now);
					if (ready_res !== want.ready_res)
						report_mismatch("ready_res", ready_res, want.ready_res);
				end
			end
			if (in_valid && !in_stall) begin
				servo_step(action, value, want);
				expected_servo.push_back(want);
			end
			waiting = expected_servo.size();
		end
	end

endmodule

// ===== sim/tb_servo_pulse_generator_unit.sv =====
`timescale 1ns / 1ps

module tb_servo_pulse_generator_unit;
	import spg_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD = 150;
	localparam logic [2:0] ACT_UNUSED_LO = 3'd5;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [2:0]           action = ACT_TICK;
	logic [VALUE_W-1:0]   value = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 pin_level;
	logic [ANGLE_W-1:0]   angle_now;
	logic                 busy_res;
	logic [PULSE_W-1:0]   pulse_now;
	logic                 ready_res;

	int mismatches;
	int waiting;
	int checked;
	int sent = 0;
	bit hold_off = 1'b0;

	servo_pulse_generator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pin_level (pin_level),
		.angle_now (angle_now),
		.busy_res  (busy_res),
		.pulse_now (pulse_now),
		.ready_res (ready_res)
	);

	servo_pulse_checker u_pulse_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pin_level  (pin_level),
		.angle_now  (angle_now),
		.busy_res   (busy_res),
		.pulse_now  (pulse_now),
		.ready_res  (ready_res),
		.mismatches (mismatches),
		.waiting    (waiting),
		.checked    (checked)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout with %0d results outstanding", waiting);
		$display("== FAIL ==");
		$finish;
	end

	// output side: random stalls, plus one long hold on request
	initial begin : receiver
		int r;
		int n;
		forever begin
			if (hold_off) begin
				hold_off = 1'b0;
				out_stall <= 1'b1;
				n = LONG_HOLD;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 45) begin
					out_stall <= 1'b0;
					n = $urandom_range(1, 25);
				end else if (r < 90) begin
					out_stall <= 1'b1;
					n = $urandom_range(1, 3);
				end else begin
					out_stall <= 1'b1;
					n = $urandom_range(6, 30);
				end
			end
			repeat (n) @(posedge clk);
		end
	end

	task automatic send(input logic [2:0] act, input logic [VALUE_W-1:0] val);
		int r;
		int gap;
		in_valid <= 1'b1;
		action <= act;
		value <= val;
		do @(posedge clk); while (in_stall !== 1'b0);
		sent++;
		r = $urandom_range(0, 99);
		gap = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_settings(input int mn, input int mx, input int ctr, input int per,
			input int bl);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= REG_MIN_PULSE;
		cfg_data <= CFG_W'(mn);
		@(posedge clk);
		cfg_index <= REG_MAX_PULSE;
		cfg_data <= CFG_W'(mx);
		@(posedge clk);
		cfg_index <= REG_CENTER_PULSE;
		cfg_data <= CFG_W'(ctr);
		@(posedge clk);
		cfg_index <= REG_PERIOD_LEN;
		cfg_data <= CFG_W'(per);
		@(posedge clk);
		cfg_index <= REG_BURST_LEN;
		cfg_data <= CFG_W'(bl);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		int r;
		int s;
		int quota;
		logic [2:0] act;
		logic [VALUE_W-1:0] val;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: commands before init leave the state unchanged, then init and the clamp cases
		send(ACT_TICK, 16'h0000);
		send(ACT_SET, 16'd45);
		send(ACT_REL, 16'd10);
		send(ACT_SPEED, 16'd5);
		send(ACT_UNUSED_LO, 16'hFFFF);
		send(ACT_UNUSED_LO + 3'd2, 16'h0000);
		send(ACT_INIT, 16'h0000);
		send(ACT_TICK, 16'h0000);
		send(ACT_TICK, 16'hFFFF);
		send(ACT_SET, 16'd0);
		send(ACT_SET, 16'd180);
		send(ACT_SET, 16'hFFFF);
		send(ACT_SET, 16'h8000);
		send(ACT_REL, 16'd0);
		send(ACT_REL, -16'sd30);
		send(ACT_REL, 16'h8000);
		send(ACT_REL, 16'h7FFF);
		send(ACT_SPEED, 16'd0);
		send(ACT_SPEED, 16'd1);
		send(ACT_SPEED, -16'sd1);
		send(ACT_SPEED, 16'h7FFF);
		send(ACT_SPEED, 16'h8000);
		send(ACT_TICK, 16'h0000);
		send(ACT_TICK, 16'h0000);

		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
			0: load_settings(2, 40, 20, 30, 3);
			1: load_settings(0, 4095, 2048, 1, 1);
			2: load_settings(4095, 0, 0, 65535, 255);
			3: load_settings(5, 25, 15, 0, 2);
			4: load_settings(3, 9, 6, 12, 0);
			5: load_settings(0, 0, 4095, 8, 255);
			default: load_settings(1, 60, 30, 64, 4);
			endcase
			if (ph == 2)
				hold_off = 1'b1;
			quota = sent + 115;
			while (sent < quota) begin
				r = $urandom_range(0, 99);
				if (r < 6) begin
					repeat ($urandom_range(10, 100)) send(ACT_TICK, 16'($urandom));
				end else if (r < 70) begin
					send(ACT_TICK, 16'($urandom));
				end else if (r < 94) begin
					act = 3'($urandom_range(int'(ACT_SET), int'(ACT_SPEED)));
					s = $urandom_range(0, 9);
					if (s < 2)
						val = 16'($urandom);
					else if (act == ACT_SET)
						val = 16'($urandom_range(0, 200));
					else
						val = 16'(int'($urandom_range(0, 400)) - 200);
					send(act, val);
				end else if (r < 97) begin
					send(ACT_INIT, 16'($urandom));
				end else begin
					send(ACT_UNUSED_LO + 3'($urandom_range(0, 2)), 16'($urandom));
				end
			end
		end

		settle();
		$display("%0d requests over 8 register settings, %0d results compared", sent, checked);
		$display("covered early commands, clamps, zero period and burst, a long output hold");
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
